/* rtl/core/hsp_pkg.sv */
// Package for the handle slot pool: widths, codes, request and response types.
// Holds the memory entry layouts as well. No dependencies.
package hsp_pkg;

    localparam int CAPACITY     = 256;
    localparam int PAYLOAD_BITS = 32;
    localparam int ADDR_W       = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    localparam logic [CNT_W-1:0] NULL_HANDLE = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] FULL_COUNT  = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FREE2,
        ST_RDATA
    } t_state;

    typedef struct packed {
        t_op         opcode;
        logic [7:0]  handle_in;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic [7:0]  handle_out;
        logic [7:0]  dense_index;
        logic [31:0] read_data;
        t_status     status;
        logic [8:0]  live_count;
    } t_rsp;

    // Handle table entry: dense slot, free-list link and free flag.
    typedef struct packed {
        logic [ADDR_W-1:0] slot;
        logic [CNT_W-1:0]  next;
        logic              is_free;
    } t_hent;

    // Slot table entry: payload word and the handle that owns the slot.
    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] payload;
        logic [ADDR_W-1:0]       owner;
    } t_sent;

endpackage

/* rtl/core/handle_slot_pool.sv */
// Handle slot pool: allocate, free, read and write of densely packed payloads (uses hsp_pkg).
// The result register loads from ST_EXEC for allocate, write and rejected requests, and from
// ST_FREE2 or ST_RDATA for free and read; a new request is taken only back in ST_IDLE.
// One request is in work at a time: registered table reads, a second slot read for a read and
// two handle table writes for a free add states; a stalled result holds off the next request.
// Reset clears the counters, the free-list head and the handshake; tables need no clearing.
module handle_slot_pool import hsp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    // Tables, indexed by handle and by dense slot.
    t_hent hmem [CAPACITY];
    t_sent smem [CAPACITY];

    t_state r_state, n_state;
    logic [CNT_W-1:0]  r_live, n_live;
    logic [CNT_W-1:0]  r_used, n_used;
    logic [CNT_W-1:0]  r_head, n_head;
    logic [ADDR_W-1:0] r_slot, n_slot;
    t_req  r_req, n_req;
    logic  r_out_valid, n_out_valid;
    t_rsp  r_rsp, n_rsp;
    t_hent r_hq;
    t_sent r_sq;

    logic              h_re, h_we, s_re, s_we;
    logic [ADDR_W-1:0] h_raddr, h_waddr, s_raddr, s_waddr;
    t_hent             h_wdata;
    t_sent             s_wdata;

    logic              accept, out_free, handle_ok;
    logic [ADDR_W-1:0] new_handle;
    t_rsp              res;

    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_rsp    = r_rsp;

    // A handle is usable when it was issued and is not on the free list.
    assign handle_ok = ({1'b0, r_req.handle_in} < r_used) && !r_hq.is_free
                       && (r_live != '0);
    assign new_handle = (r_head == NULL_HANDLE) ? r_used[ADDR_W-1:0]
                                                : r_head[ADDR_W-1:0];

    // Next state, table accesses and result.
    always_comb begin
        n_state     = r_state;
        n_live      = r_live;
        n_used      = r_used;
        n_head      = r_head;
        n_slot      = r_slot;
        n_req       = r_req;
        n_out_valid = r_out_valid && i_stall;
        n_rsp       = r_rsp;
        h_re        = 1'b0;
        h_we        = 1'b0;
        s_re        = 1'b0;
        s_we        = 1'b0;
        h_raddr     = i_req.handle_in;
        h_waddr     = new_handle;
        s_raddr     = r_live[ADDR_W-1:0] - ADDR_W'(1);
        s_waddr     = r_live[ADDR_W-1:0];
        h_wdata     = r_hq;
        s_wdata     = r_sq;
        res         = '0;
        res.status  = STAT_OK;
        res.live_count = r_live;

        case (r_state)
            ST_IDLE: begin
                // Read the handle entry and the last slot for the new request.
                if (accept) begin
                    n_req   = i_req;
                    h_re    = 1'b1;
                    s_re    = 1'b1;
                    if (i_req.opcode == OP_ALLOC) begin
                        h_raddr = r_head[ADDR_W-1:0];
                    end
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_req.opcode == OP_ALLOC) begin
                    if (r_live == FULL_COUNT) begin
                        res.status = STAT_FULL;
                    end else begin
                        res.handle_out  = new_handle;
                        res.dense_index = r_live[ADDR_W-1:0];
                        res.live_count  = r_live + CNT_W'(1);
                    end
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_rsp       = res;
                        n_state     = ST_IDLE;
                        if (r_live != FULL_COUNT) begin
                            // Bind the handle to the end of the dense array.
                            h_we          = 1'b1;
                            h_waddr       = new_handle;
                            h_wdata.slot  = r_live[ADDR_W-1:0];
                            h_wdata.next  = r_hq.next;
                            h_wdata.is_free = 1'b0;
                            s_we          = 1'b1;
                            s_waddr       = r_live[ADDR_W-1:0];
                            s_wdata.payload = '0;
                            s_wdata.owner = new_handle;
                            n_live        = r_live + CNT_W'(1);
                            if (r_head == NULL_HANDLE) begin
                                n_used = r_used + CNT_W'(1);
                            end else begin
                                n_head = r_hq.next;
                            end
                        end
                    end
                end else if (!handle_ok) begin
                    res.status = STAT_BAD;
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_rsp       = res;
                        n_state     = ST_IDLE;
                    end
                end else if (r_req.opcode == OP_FREE) begin
                    // Move the last payload into the hole and repoint its handle.
                    n_slot          = r_hq.slot;
                    s_we            = 1'b1;
                    s_waddr         = r_hq.slot;
                    s_wdata         = r_sq;
                    h_we            = 1'b1;
                    h_waddr         = r_sq.owner;
                    h_wdata.slot    = r_hq.slot;
                    h_wdata.next    = r_head;
                    h_wdata.is_free = 1'b0;
                    n_state         = ST_FREE2;
                end else if (r_req.opcode == OP_READ) begin
                    n_slot  = r_hq.slot;
                    s_re    = 1'b1;
                    s_raddr = r_hq.slot;
                    n_state = ST_RDATA;
                end else begin
                    res.dense_index = r_hq.slot;
                    if (out_free) begin
                        n_out_valid     = 1'b1;
                        n_rsp           = res;
                        n_state         = ST_IDLE;
                        s_we            = 1'b1;
                        s_waddr         = r_hq.slot;
                        s_wdata.payload = r_req.write_data[PAYLOAD_BITS-1:0];
                        s_wdata.owner   = r_req.handle_in;
                    end
                end
            end
            ST_FREE2: begin
                res.dense_index = r_slot;
                res.live_count  = r_live - CNT_W'(1);
                if (out_free) begin
                    // Push the freed handle onto the free list.
                    n_out_valid     = 1'b1;
                    n_rsp           = res;
                    n_state         = ST_IDLE;
                    h_we            = 1'b1;
                    h_waddr         = r_req.handle_in;
                    h_wdata.slot    = r_slot;
                    h_wdata.next    = r_head;
                    h_wdata.is_free = 1'b1;
                    n_live          = r_live - CNT_W'(1);
                    n_head          = {1'b0, r_req.handle_in};
                    if (r_live == CNT_W'(1)) begin
                        n_head = NULL_HANDLE;
                        n_used = '0;
                    end
                end
            end
            ST_RDATA: begin
                res.dense_index = r_slot;
                res.read_data   = r_sq.payload;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_rsp       = res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_live      <= '0;
            r_used      <= '0;
            r_head      <= NULL_HANDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_used      <= n_used;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_req  <= n_req;
        r_rsp  <= n_rsp;
    end

    // Handle table with registered read.
    always_ff @(posedge i_clk) begin
        if (h_we) begin
            hmem[h_waddr] <= h_wdata;
        end
        if (h_re) begin
            r_hq <= hmem[h_raddr];
        end
    end

    // Slot table with registered read.
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            smem[s_waddr] <= s_wdata;
        end
        if (s_re) begin
            r_sq <= smem[s_raddr];
        end
    end

endmodule
